// ===== rtl/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// shared constants, types and helpers of the serial command packet parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  // receive buffer length, start byte included
  localparam int PACKET_LEN = 16;
  localparam int POS_W      = $clog2(PACKET_LEN + 1);
  localparam int ACC_W      = 17;
  localparam int LEVEL_W    = 16;

  // buffer positions with a meaning of their own
  localparam logic [POS_W-1:0] POS_CMD       = POS_W'(1);
  localparam logic [POS_W-1:0] POS_DIG_FIRST = POS_W'(2);
  localparam logic [POS_W-1:0] POS_DIG_LAST  = POS_W'(6);
  localparam logic [POS_W-1:0] POS_SEVENTH   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_LIMIT     = POS_W'(PACKET_LEN);

  // characters
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_CASE  = 8'h20;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_W     = 8'h77;

  // action codes
  localparam logic [2:0] ACT_MODE   = 3'd0;
  localparam logic [2:0] ACT_VALUE  = 3'd1;
  localparam logic [2:0] ACT_REPORT = 3'd2;
  localparam logic [2:0] ACT_HIGH   = 3'd3;
  localparam logic [2:0] ACT_NONE   = 3'd4;

  // what the packet tracker hands to the command stage at end of packet
  typedef struct packed {
    logic [7:0]       cmd;
    logic [ACC_W-1:0] acc;
    logic             seventh;
  } exec_req_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [1:0]         led_mode;
    logic               custom_active;
    logic [LEVEL_W-1:0] led_level;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scp_if.sv =====
// ----------------------------------------------------------------------------
// scp_in_if / scp_out_if
// valid/ready channels for received words and for command results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [1:0]  led_mode;
  logic        custom_active;
  logic [15:0] led_level;

  modport source (output valid, output action, output led_mode,
                  output custom_active, output led_level, input ready);
  modport sink   (input valid, input action, input led_mode,
                  input custom_active, input led_level, output ready);
endinterface

`default_nettype wire

// ===== rtl/scp_packet.sv =====
// ----------------------------------------------------------------------------
// scp_packet
// packet framing, command capture and decimal digit scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_packet (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  input  logic [7:0]          rx_byte,
  input  logic                fire,
  output logic                pend,
  output scp_pkg::exec_req_t  req
);
  import scp_pkg::*;

  logic             in_packet,         in_packet_next;
  logic [POS_W-1:0] char_position,     char_position_next;
  logic [7:0]       command_char,      command_char_next;
  logic [ACC_W-1:0] digit_accumulator, digit_accumulator_next;
  logic             digits_running,    digits_running_next;
  logic             seventh_is_digit,  seventh_is_digit_next;

  logic             dig;
  logic             in_range;
  logic [ACC_W-1:0] acc_x10;

  assign dig      = is_digit(rx_byte);
  assign in_range = char_position < POS_LIMIT;
  assign acc_x10  = {digit_accumulator[ACC_W-4:0], 3'b000}
                  + {digit_accumulator[ACC_W-2:0], 1'b0};

  always_comb begin
    in_packet_next         = in_packet;
    char_position_next     = char_position;
    command_char_next      = command_char;
    digit_accumulator_next = digit_accumulator;
    digits_running_next    = digits_running;
    seventh_is_digit_next  = seventh_is_digit;
    if (rx_byte == CH_START) begin
      in_packet_next         = 1'b1;
      char_position_next     = POS_CMD;
      command_char_next      = '0;
      digit_accumulator_next = '0;
      digits_running_next    = 1'b1;
      seventh_is_digit_next  = 1'b0;
    end else if (in_packet && !in_range) begin
      // overrun: drop silently
      in_packet_next = 1'b0;
    end else if (in_packet) begin
      if (char_position == POS_CMD) begin
        command_char_next = rx_byte;
      end
      if (char_position >= POS_DIG_FIRST && char_position <= POS_DIG_LAST) begin
        if (digits_running && dig) begin
          digit_accumulator_next = acc_x10 + ACC_W'(rx_byte - CH_ZERO);
        end else begin
          digits_running_next = 1'b0;
        end
      end
      if (char_position == POS_SEVENTH) begin
        seventh_is_digit_next = dig;
      end
      char_position_next = char_position + POS_W'(1);
      if (rx_byte == CH_END) begin
        in_packet_next = 1'b0;
      end
    end
  end

  assign pend = valid && in_packet && in_range && (rx_byte == CH_END);

  // the end byte is no digit, so the scan values are those already held
  assign req.cmd     = (char_position == POS_CMD) ? rx_byte : command_char;
  assign req.acc     = digit_accumulator;
  assign req.seventh = (char_position == POS_SEVENTH) ? 1'b0 : seventh_is_digit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet         <= 1'b0;
      char_position     <= '0;
      command_char      <= '0;
      digit_accumulator <= '0;
      digits_running    <= 1'b1;
      seventh_is_digit  <= 1'b0;
    end else if (fire) begin
      in_packet         <= in_packet_next;
      char_position     <= char_position_next;
      command_char      <= command_char_next;
      digit_accumulator <= digit_accumulator_next;
      digits_running    <= digits_running_next;
      seventh_is_digit  <= seventh_is_digit_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scp_exec.sv =====
// ----------------------------------------------------------------------------
// scp_exec
// command decode and led mode / level state
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scp_exec (
  input  logic               clk,
  input  logic               rst,
  input  logic               commit,
  input  scp_pkg::exec_req_t req,
  output scp_pkg::result_t   result
);
  import scp_pkg::*;

  logic [1:0]         mode_reg,   mode_reg_next;
  logic               custom_reg, custom_reg_next;
  logic [LEVEL_W-1:0] level_reg,  level_reg_next;
  logic [7:0]         c;
  logic [7:0]         c_off;
  logic [2:0]         act;

  always_comb begin
    c = req.cmd;
    if (req.cmd >= CH_UP_A && req.cmd <= CH_UP_Z) begin
      c = req.cmd + CH_CASE;
    end
    c_off           = c - CH_R;
    mode_reg_next   = mode_reg;
    custom_reg_next = custom_reg;
    level_reg_next  = level_reg;
    act             = ACT_NONE;
    unique case (c) inside
      [CH_R:CH_U]: begin
        act             = ACT_MODE;
        mode_reg_next   = c_off[1:0];
        custom_reg_next = 1'b0;
      end
      CH_V: begin
        act = ACT_REPORT;
      end
      CH_W: begin
        // above 65535 shows as the top accumulator bit
        if (req.seventh || req.acc[ACC_W-1]) begin
          act = ACT_HIGH;
        end else begin
          act             = ACT_VALUE;
          mode_reg_next   = 2'd0;
          custom_reg_next = 1'b1;
          level_reg_next  = req.acc[LEVEL_W-1:0];
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  assign result.action        = act;
  assign result.led_mode      = mode_reg_next;
  assign result.custom_active = custom_reg_next;
  assign result.led_level     = level_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= 2'd0;
      custom_reg <= 1'b0;
      level_reg  <= '0;
    end else if (commit) begin
      mode_reg   <= mode_reg_next;
      custom_reg <= custom_reg_next;
      level_reg  <= level_reg_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/serial_command_packet_parser_unit.sv =====
// ----------------------------------------------------------------------------
// serial_command_packet_parser_unit
// byte-wide command packet parser for led mode and level control
// ----------------------------------------------------------------------------
// Takes one received word per cycle on rx and gives one result word on res
// for every packet that executes. A '$' opens a packet anywhere, bytes
// outside a packet are dropped, and '\n' executes it: r/s/t/u (any case) set
// the led mode, v asks for a report, w loads a decimal level of up to five
// digits, or reports it too high. A packet longer than the receive buffer is
// dropped without a result. Each word passes an input register and the
// decode logic; a result is written to the output register when its end
// word leaves the input register. Throughput is one word per cycle while rx
// does not stall; rx stalls only when a result is ready to leave while the
// output register is still held by res.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_command_packet_parser_unit (
  input  logic      clk,
  input  logic      rst,
  scp_in_if.sink    rx,
  scp_out_if.source res
);
  import scp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // decode stage
  logic       pend;
  logic       s1_fire;
  logic       out_free;
  exec_req_t  req;
  result_t    result;

  // output register
  logic       out_valid;
  result_t    out_data;

  assign out_free = !out_valid || res.ready;
  // a word that gives no result never waits for the output side
  assign s1_fire  = s1_valid && (!pend || out_free);
  assign rx.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  scp_packet u_packet (
    .clk     (clk),
    .rst     (rst),
    .valid   (s1_valid),
    .rx_byte (s1_byte),
    .fire    (s1_fire),
    .pend    (pend),
    .req     (req)
  );

  scp_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .commit (s1_fire && pend),
    .req    (req),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && pend) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && pend) begin
      out_data <= result;
    end
  end

  assign res.valid         = out_valid;
  assign res.action        = out_data.action;
  assign res.led_mode      = out_data.led_mode;
  assign res.custom_active = out_data.custom_active;
  assign res.led_level     = out_data.led_level;

  // a result never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready && s1_valid && pend) |-> !s1_fire)
    else $error("result overwritten while held");

  // words with no result leave the output register alone
  a_quiet_word: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && !pend) |=> (out_valid == $past(out_valid && !res.ready)))
    else $error("output register changed on a word with no result");

  // a level load puts the custom level in force in mode zero
  a_value_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == ACT_VALUE) |->
      (out_data.custom_active && out_data.led_mode == 2'd0))
    else $error("value set without custom level in force");

  // a mode command drops the custom level
  a_mode_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.action == ACT_MODE) |-> !out_data.custom_active)
    else $error("mode set left custom level in force");

endmodule

`default_nettype wire
